// ===== rtl/core/drcf_pkg.sv =====
package drcf_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_C,
        ST_MUL_F,
        ST_CONV_F,
        ST_DECIDE,
        ST_DIV,
        ST_MUL_B,
        ST_BLEND,
        ST_OUT
    } fsm_state_t;

    // Range codes
    localparam logic [1:0] RNG_UNKNOWN = 2'd0;
    localparam logic [1:0] RNG_LOW     = 2'd1;
    localparam logic [1:0] RNG_MID     = 2'd2;
    localparam logic [1:0] RNG_HIGH    = 2'd3;

    // Result source codes
    localparam logic [1:0] SRC_COARSE = 2'd0;
    localparam logic [1:0] SRC_FINE   = 2'd1;
    localparam logic [1:0] SRC_BLEND  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_SETTLE_COUNT     = 3'd0;
    localparam logic [2:0] REG_BLEND_COUNT      = 3'd1;
    localparam logic [2:0] REG_TRUST_LIMIT_HIGH = 3'd2;
    localparam logic [2:0] REG_TRUST_LIMIT_MID  = 3'd3;
    localparam logic [2:0] REG_GAIN_COARSE      = 3'd4;
    localparam logic [2:0] REG_GAIN_MID         = 3'd5;
    localparam logic [2:0] REG_GAIN_HIGH        = 3'd6;

    // Register widths and reset values
    localparam int CNT_REG_BITS   = 16;
    localparam int LIMIT_BITS     = 31;
    localparam int GAIN_BITS      = 32;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [LIMIT_BITS-1:0] TRUST_HIGH_RST = 31'd1400000;
    localparam logic [LIMIT_BITS-1:0] TRUST_MID_RST  = 31'd36000000;
    localparam logic [GAIN_BITS-1:0]  GAIN_RST       = 32'd65536;

    // Blend weight: Q1.16, one is 2^16; 17 quotient bits from the divider
    localparam int                 W_BITS    = 17;
    localparam logic [W_BITS-1:0]  W_ONE     = 17'h10000;
    localparam logic [4:0]         DIV_LAST  = 5'd16;

endpackage

// ===== rtl/core/dual_range_current_fusion_unit.sv =====
// Flow: s_tready is high only while the sequencer is idle, so a new request is accepted only
// after the previous result has been loaded into the output register; a stall holds it off.
// Sequence: the direct path runs two multiplier passes (coarse, fine) plus decide before
// m_tvalid rises; a cross-fade adds a 17-step restoring divider, then one more multiply,
// and a weight that clamps to one skips the divider.
// Reset: aresetn synchronous, active low; configuration registers return to defaults, range unknown.
module dual_range_current_fusion_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [2:0]                             cfg_addr,
    input  logic [drcf_pkg::CFG_DATA_BITS-1:0]     cfg_wr_data,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // fine_sample, coarse_sample, zero pad
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    // range_code[1:0], fine_ok, coarse_ok
    input  logic [3:0]                             s_tuser,
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // current_na
    output logic [31:0]                            m_tdata,
    // source[1:0], coarse_missing, range_echo[1:0]
    output logic [4:0]                             m_tuser
);
    import drcf_pkg::*;

    localparam int CMP_BITS = (COUNT_BITS > CNT_REG_BITS) ? COUNT_BITS : CNT_REG_BITS;

    // Saturate a sign and magnitude to 32-bit signed
    function automatic logic [31:0] sat32(input logic neg, input logic [47:0] mag);
        logic [31:0] r;
        if (neg) begin
            if (mag >= 48'h8000_0000) r = 32'h8000_0000;
            else                      r = 32'(-mag[31:0]);
        end else begin
            if (mag > 48'h7FFF_FFFF) r = 32'h7FFF_FFFF;
            else                     r = mag[31:0];
        end
        return r;
    endfunction

    // Magnitude of a sample code
    function automatic logic [31:0] code_mag(input logic [SAMPLE_BITS-1:0] code);
        logic signed [SAMPLE_BITS:0] ext;
        logic signed [SAMPLE_BITS:0] m;
        ext = $signed({code[SAMPLE_BITS-1], code});
        m   = code[SAMPLE_BITS-1] ? -ext : ext;
        return 32'(unsigned'(m));
    endfunction

    // Configuration registers
    logic [CNT_REG_BITS-1:0] settle_count_reg;
    logic [CNT_REG_BITS-1:0] blend_count_reg;
    logic [LIMIT_BITS-1:0]   trust_high_reg;
    logic [LIMIT_BITS-1:0]   trust_mid_reg;
    logic [GAIN_BITS-1:0]    gain_coarse_reg;
    logic [GAIN_BITS-1:0]    gain_mid_reg;
    logic [GAIN_BITS-1:0]    gain_high_reg;

    // Tracking state
    logic [1:0]            prev_range_reg;
    logic [COUNT_BITS-1:0] settle_left_reg;
    logic [COUNT_BITS-1:0] blend_left_reg;

    // Sequencer
    fsm_state_t state_reg, state_next;

    // Captured request
    logic [1:0]             range_reg;
    logic                   fine_ok_reg;
    logic                   coarse_ok_reg;
    logic [SAMPLE_BITS-1:0] fine_code_reg;
    logic [SAMPLE_BITS-1:0] coarse_code_reg;

    // Datapath
    logic [63:0]             prod_reg;
    logic [31:0]             coarse_na_reg;
    logic [31:0]             fine_na_reg;
    logic [CNT_REG_BITS:0]   rem_reg;
    logic [W_BITS-1:0]       w_reg;
    logic [4:0]              step_reg;
    logic                    diff_neg_reg;
    logic [31:0]             res_reg;
    logic [1:0]              src_reg;
    logic                    missing_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [31:0] m_data_reg;
    logic [4:0]  m_user_reg;

    logic                   s_accept;
    logic [1:0]             in_range;
    logic [SAMPLE_BITS-1:0] in_fine;
    logic [SAMPLE_BITS-1:0] in_coarse;

    assign in_range  = s_tuser[1:0];
    assign in_fine   = s_tdata[SAMPLE_BITS-1:0];
    assign in_coarse = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Shared multiplier operand select
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic signed [32:0] diff;
    logic [31:0] diff_mag;

    assign diff     = $signed({coarse_na_reg[31], coarse_na_reg})
                    - $signed({fine_na_reg[31], fine_na_reg});
    assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];

    always_comb begin
        case (state_reg)
            ST_MUL_C: begin
                mul_a = coarse_ok_reg ? code_mag(coarse_code_reg) : 32'd0;
                mul_b = gain_coarse_reg;
            end
            ST_MUL_F: begin
                mul_a = fine_ok_reg ? code_mag(fine_code_reg) : 32'd0;
                mul_b = (range_reg == RNG_HIGH) ? gain_high_reg : gain_mid_reg;
            end
            ST_MUL_B: begin
                mul_a = diff_mag;
                mul_b = 32'(w_reg);
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // Trust window check on the converted fine current
    logic [31:0]           fine_abs;
    logic [LIMIT_BITS-1:0] limit;
    logic                  trusted;
    logic                  is_known_fine;
    logic                  blend_clamp;

    assign fine_abs      = fine_na_reg[31] ? 32'(-fine_na_reg) : fine_na_reg;
    assign limit         = (range_reg == RNG_HIGH) ? trust_high_reg : trust_mid_reg;
    assign trusted       = fine_ok_reg && (fine_abs <= {1'b0, limit});
    assign is_known_fine = (range_reg == RNG_MID) || (range_reg == RNG_HIGH);
    assign blend_clamp   = CMP_BITS'(blend_left_reg) > CMP_BITS'(blend_count_reg);

    // Divider step: compare and subtract
    logic                  div_ge;
    logic [CNT_REG_BITS:0] div_rem;

    assign div_ge  = rem_reg >= {1'b0, blend_count_reg};
    assign div_rem = div_ge ? rem_reg - {1'b0, blend_count_reg} : rem_reg;

    // Blend sum: fine * 2^16 + w * (coarse - fine)
    logic signed [49:0] blend_sum;
    logic [49:0]        blend_abs;

    assign blend_sum = $signed({{2{fine_na_reg[31]}}, fine_na_reg, 16'd0})
                     + (diff_neg_reg ? -$signed({2'b00, prod_reg[47:0]})
                                     :  $signed({2'b00, prod_reg[47:0]}));
    assign blend_abs = blend_sum[49] ? 50'(-blend_sum) : 50'(blend_sum);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_MUL_C;
            ST_MUL_C:  state_next = ST_MUL_F;
            ST_MUL_F:  state_next = ST_CONV_F;
            ST_CONV_F: state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (is_known_fine && settle_left_reg == '0 && trusted &&
                    blend_left_reg != '0 && blend_count_reg != '0) begin
                    state_next = blend_clamp ? ST_MUL_B : ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:    if (step_reg == DIV_LAST) state_next = ST_MUL_B;
            ST_MUL_B:  state_next = ST_BLEND;
            ST_BLEND:  state_next = ST_OUT;
            ST_OUT:    if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_count_reg <= '0;
            blend_count_reg  <= '0;
            trust_high_reg   <= TRUST_HIGH_RST;
            trust_mid_reg    <= TRUST_MID_RST;
            gain_coarse_reg  <= GAIN_RST;
            gain_mid_reg     <= GAIN_RST;
            gain_high_reg    <= GAIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SETTLE_COUNT:     settle_count_reg <= cfg_wr_data[CNT_REG_BITS-1:0];
                REG_BLEND_COUNT:      blend_count_reg  <= cfg_wr_data[CNT_REG_BITS-1:0];
                REG_TRUST_LIMIT_HIGH: trust_high_reg   <= cfg_wr_data[LIMIT_BITS-1:0];
                REG_TRUST_LIMIT_MID:  trust_mid_reg    <= cfg_wr_data[LIMIT_BITS-1:0];
                REG_GAIN_COARSE:      gain_coarse_reg  <= cfg_wr_data[GAIN_BITS-1:0];
                REG_GAIN_MID:         gain_mid_reg     <= cfg_wr_data[GAIN_BITS-1:0];
                REG_GAIN_HIGH:        gain_high_reg    <= cfg_wr_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Range tracking and countdowns
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_range_reg  <= RNG_UNKNOWN;
            settle_left_reg <= '0;
            blend_left_reg  <= '0;
        end else if (s_accept) begin
            prev_range_reg <= in_range;
            if (in_range != prev_range_reg && prev_range_reg != RNG_UNKNOWN) begin
                settle_left_reg <= COUNT_BITS'(settle_count_reg);
                blend_left_reg  <= '0;
            end
        end else if (state_reg == ST_DECIDE && is_known_fine) begin
            if (settle_left_reg != '0) begin
                settle_left_reg <= settle_left_reg - 1'b1;
                if (settle_left_reg == COUNT_BITS'(1) && trusted)
                    blend_left_reg <= COUNT_BITS'(blend_count_reg);
            end else if (trusted && blend_left_reg != '0 && blend_count_reg != '0) begin
                blend_left_reg <= blend_left_reg - 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            range_reg       <= in_range;
            fine_ok_reg     <= s_tuser[2];
            coarse_ok_reg   <= s_tuser[3];
            fine_code_reg   <= in_fine;
            coarse_code_reg <= in_coarse;
        end

        if (state_reg == ST_MUL_C || state_reg == ST_MUL_F || state_reg == ST_MUL_B)
            prod_reg <= mul_a * mul_b;

        if (state_reg == ST_MUL_F)
            coarse_na_reg <= sat32(coarse_code_reg[SAMPLE_BITS-1], 48'(prod_reg[63:16]));
        if (state_reg == ST_CONV_F)
            fine_na_reg <= sat32(fine_code_reg[SAMPLE_BITS-1], 48'(prod_reg[63:16]));

        case (state_reg)
            ST_DECIDE: begin
                missing_reg <= !is_known_fine && !coarse_ok_reg;
                if (is_known_fine && settle_left_reg == '0 && trusted &&
                    !(blend_left_reg != '0 && blend_count_reg != '0)) begin
                    res_reg <= fine_na_reg;
                    src_reg <= SRC_FINE;
                end else begin
                    res_reg <= coarse_na_reg;
                    src_reg <= SRC_COARSE;
                end
                // divider start: the divider runs only when blend_left is at most blend_count
                rem_reg  <= {1'b0, CNT_REG_BITS'(blend_left_reg)};
                w_reg    <= blend_clamp ? W_ONE : '0;
                step_reg <= '0;
            end
            ST_DIV: begin
                rem_reg  <= {div_rem[CNT_REG_BITS-1:0], 1'b0};
                w_reg    <= {w_reg[W_BITS-2:0], div_ge};
                step_reg <= step_reg + 1'b1;
            end
            ST_MUL_B: begin
                diff_neg_reg <= diff[32];
            end
            ST_BLEND: begin
                res_reg <= sat32(blend_sum[49], 48'(blend_abs[49:16]));
                src_reg <= SRC_BLEND;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_data_reg <= res_reg;
            m_user_reg <= {range_reg, missing_reg, src_reg};
        end
    end

`ifndef SYNTHESIS
    // An accepted request always starts with the coarse multiply
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_MUL_C)
        else $error("accepted request did not start conversion");

    // Cross-fade results only on mid or high range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == SRC_BLEND |-> m_tuser[4:3] == RNG_MID ||
            m_tuser[4:3] == RNG_HIGH)
        else $error("blend result on a coarse-only range");

    // Missing-coarse flag only on low or unknown range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[4:3] == RNG_UNKNOWN ||
            m_tuser[4:3] == RNG_LOW)
        else $error("coarse_missing set on a fine range");

    // Divider never runs past its last step
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> step_reg <= DIV_LAST)
        else $error("divider step count overrun");

    // Output register is empty right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

// ===== sim/tb_dual_range_current_fusion_unit.sv =====
module tb_dual_range_current_fusion_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import drcf_pkg::*;

    // One request: range code, two converter samples and their valid flags
    typedef struct {
        logic [1:0]         range;
        logic               fine_ok;
        logic signed [23:0] fine;
        logic               coarse_ok;
        logic signed [23:0] coarse;
    } fusion_sample_t;

    // One fused reading
    typedef struct {
        logic signed [31:0] current_na;
        logic [1:0]         source;
        logic               missing;
        logic [1:0]         range;
    } fusion_reading_t;

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [2:0]               cfg_addr    = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data = '0;
    logic                     s_tvalid    = 1'b0;
    logic                     s_tready;
    logic [47:0]              s_tdata     = '0;
    logic [3:0]               s_tuser     = '0;
    logic                     m_tvalid;
    logic                     m_tready    = 1'b0;
    logic [31:0]              m_tdata;
    logic [4:0]               m_tuser;

    // Idle percentages for the two sides
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    fusion_reading_t expected_readings[$];

    // Shadow of the register file
    logic [15:0] cfg_settle      = 16'd0;
    logic [15:0] cfg_blend       = 16'd0;
    logic [30:0] cfg_limit_high  = TRUST_HIGH_RST;
    logic [30:0] cfg_limit_mid   = TRUST_MID_RST;
    logic [31:0] cfg_gain_coarse = GAIN_RST;
    logic [31:0] cfg_gain_mid    = GAIN_RST;
    logic [31:0] cfg_gain_high   = GAIN_RST;

    // Shadow of the sequencing state
    logic [1:0]  prev_range_seen = RNG_UNKNOWN;
    logic [15:0] settle_left     = 16'd0;
    logic [15:0] blend_left      = 16'd0;

    dual_range_current_fusion_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Clamp a sign and magnitude to 32 bit signed
    function automatic logic signed [31:0] sat_current(input logic neg, input longint mag);
        if (neg) begin
            if (mag >= 64'sh8000_0000) return 32'sh8000_0000;
            return -mag[31:0];
        end
        if (mag > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        return mag[31:0];
    endfunction

    // Code times Q16.16 gain, truncated toward zero
    function automatic logic signed [31:0] code_to_na(input logic signed [23:0] code,
                                                       input logic [31:0] gain);
        longint c;
        longint mag;
        c   = code;
        mag = (c < 0) ? -c : c;
        mag = (mag * longint'(gain)) >>> 16;
        return sat_current(c < 0, mag);
    endfunction

    function automatic logic signed [31:0] cross_fade(input logic signed [31:0] coarse_na,
                                                       input logic signed [31:0] fine_na,
                                                       input longint w);
        longint sum;
        longint mag;
        sum = w * longint'(coarse_na) + (64'sd65536 - w) * longint'(fine_na);
        mag = (sum < 0) ? -sum : sum;
        return sat_current(sum < 0, mag >>> 16);
    endfunction

    // Advance the shadow state by one request and return its reading
    function automatic fusion_reading_t predict_fusion(input fusion_sample_t s);
        fusion_reading_t    r;
        logic signed [31:0] coarse_na;
        logic signed [31:0] fine_na;
        logic [31:0]        gain;
        longint             limit;
        longint             fine_mag;
        longint             w;
        logic               trusted;

        if (s.range != prev_range_seen) begin
            if (prev_range_seen != RNG_UNKNOWN) begin
                settle_left = cfg_settle;
                blend_left  = 16'd0;
            end
            prev_range_seen = s.range;
        end

        coarse_na    = s.coarse_ok ? code_to_na(s.coarse, cfg_gain_coarse) : 32'sd0;
        r.current_na = coarse_na;
        r.source     = SRC_COARSE;
        r.missing    = 1'b0;
        r.range      = s.range;

        if (s.range == RNG_UNKNOWN || s.range == RNG_LOW) begin
            r.missing = !s.coarse_ok;
        end else begin
            gain     = (s.range == RNG_HIGH) ? cfg_gain_high : cfg_gain_mid;
            limit    = (s.range == RNG_HIGH) ? cfg_limit_high : cfg_limit_mid;
            fine_na  = s.fine_ok ? code_to_na(s.fine, gain) : 32'sd0;
            fine_mag = (fine_na < 0) ? -longint'(fine_na) : longint'(fine_na);
            trusted  = s.fine_ok && (fine_mag <= limit);

            if (settle_left != 0) begin
                settle_left = settle_left - 16'd1;
                if (settle_left == 0 && trusted) blend_left = cfg_blend;
            end else if (trusted) begin
                if (blend_left != 0 && cfg_blend != 0) begin
                    w = (longint'(blend_left) << 16) / longint'(cfg_blend);
                    if (w > 64'sd65536) w = 64'sd65536;
                    blend_left   = blend_left - 16'd1;
                    r.current_na = cross_fade(coarse_na, fine_na, w);
                    r.source     = SRC_BLEND;
                end else begin
                    r.current_na = fine_na;
                    r.source     = SRC_FINE;
                end
            end
        end
        return r;
    endfunction

    function automatic fusion_sample_t make_request(input logic [1:0] range,
                                                    input logic fine_ok,
                                                    input int fine,
                                                    input logic coarse_ok,
                                                    input int coarse);
        fusion_sample_t s;
        s.range     = range;
        s.fine_ok   = fine_ok;
        s.fine      = fine[23:0];
        s.coarse_ok = coarse_ok;
        s.coarse    = coarse[23:0];
        return s;
    endfunction

    // Register write; only called while the block is idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            REG_SETTLE_COUNT:     cfg_settle      = value[15:0];
            REG_BLEND_COUNT:      cfg_blend       = value[15:0];
            REG_TRUST_LIMIT_HIGH: cfg_limit_high  = value[30:0];
            REG_TRUST_LIMIT_MID:  cfg_limit_mid   = value[30:0];
            REG_GAIN_COARSE:      cfg_gain_coarse = value;
            REG_GAIN_MID:         cfg_gain_mid    = value;
            REG_GAIN_HIGH:        cfg_gain_high   = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Send one request, with random idle cycles in front of it
    task automatic send_request(input fusion_sample_t s);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s.coarse, s.fine};
        s_tuser  <= {s.coarse_ok, s.fine_ok, s.range};
        do @(posedge aclk); while (!s_tready);
        expected_readings.push_back(predict_fusion(s));
    endtask

    // Stop sending and wait until every reading has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endtask

    // Default registers: range handling, field extremes, trust window edges
    task automatic test_reset_defaults();
        set_idle_mode(3);
        send_request(make_request(RNG_UNKNOWN, 1'b1, -8388608, 1'b1, 8388607));
        send_request(make_request(RNG_LOW, 1'b1, 8388607, 1'b0, 1234));
        send_request(make_request(RNG_UNKNOWN, 1'b0, 0, 1'b1, -8388608));
        send_request(make_request(RNG_MID, 1'b1, 8388607, 1'b1, -77));
        send_request(make_request(RNG_MID, 1'b1, -8388608, 1'b1, 77));
        send_request(make_request(RNG_MID, 1'b0, 5000, 1'b0, 6000));
        send_request(make_request(RNG_HIGH, 1'b1, 1400000, 1'b1, 1));
        send_request(make_request(RNG_HIGH, 1'b1, 1400001, 1'b1, 2));
        send_request(make_request(RNG_HIGH, 1'b1, -1400000, 1'b1, 3));
        wait_idle();
    endtask

    // Largest and zero gains drive both saturation limits
    task automatic test_saturation();
        set_idle_mode(0);
        write_reg(REG_GAIN_COARSE, 32'hFFFF_FFFF);
        write_reg(REG_GAIN_HIGH, 32'hFFFF_FFFF);
        write_reg(REG_GAIN_MID, 32'd0);
        write_reg(REG_TRUST_LIMIT_HIGH, 32'h7FFF_FFFF);
        write_reg(REG_TRUST_LIMIT_MID, 32'h7FFF_FFFF);
        send_request(make_request(RNG_UNKNOWN, 1'b0, 0, 1'b1, 8388607));
        send_request(make_request(RNG_LOW, 1'b0, 0, 1'b1, -8388608));
        // magnitude 2^31 lies just outside the widest window
        send_request(make_request(RNG_HIGH, 1'b1, -8388608, 1'b1, 100));
        send_request(make_request(RNG_HIGH, 1'b1, 8388607, 1'b1, -100));
        send_request(make_request(RNG_MID, 1'b1, 12345, 1'b1, 100));
        wait_idle();
    endtask

    // Settle countdown survives an unknown range, then a full cross-fade to fine
    task automatic test_settle_blend();
        set_idle_mode(1);
        write_reg(REG_GAIN_COARSE, GAIN_RST);
        write_reg(REG_GAIN_MID, GAIN_RST);
        write_reg(REG_GAIN_HIGH, GAIN_RST);
        write_reg(REG_TRUST_LIMIT_HIGH, 32'(TRUST_HIGH_RST));
        write_reg(REG_TRUST_LIMIT_MID, 32'(TRUST_MID_RST));
        write_reg(REG_SETTLE_COUNT, 32'd3);
        write_reg(REG_BLEND_COUNT, 32'd4);
        // leaving mid loads the countdown; unknown does not consume it
        send_request(make_request(RNG_UNKNOWN, 1'b1, 10, 1'b1, 20));
        for (int i = 0; i < 8; i++)
            send_request(make_request(RNG_HIGH, 1'b1, 1000000 - 1000 * i, 1'b1, -900000));
        wait_idle();
    endtask

    // Blend counter above a lowered blend count, then blending switched off
    task automatic test_blend_clamp();
        set_idle_mode(2);
        write_reg(REG_SETTLE_COUNT, 32'd1);
        write_reg(REG_BLEND_COUNT, 32'd8);
        send_request(make_request(RNG_MID, 1'b1, 500000, 1'b1, 400000));
        send_request(make_request(RNG_HIGH, 1'b1, 1000000, 1'b1, 900000));
        send_request(make_request(RNG_HIGH, 1'b1, 1000000, 1'b1, 900000));
        send_request(make_request(RNG_HIGH, 1'b1, -1000000, 1'b1, 900000));
        wait_idle();
        write_reg(REG_BLEND_COUNT, 32'd3);
        send_request(make_request(RNG_HIGH, 1'b1, 1000000, 1'b1, -900000));
        // untrusted fine in mid-blend falls back to coarse
        send_request(make_request(RNG_HIGH, 1'b1, 2000000, 1'b1, -900000));
        wait_idle();
        write_reg(REG_BLEND_COUNT, 32'd0);
        send_request(make_request(RNG_HIGH, 1'b1, 1000000, 1'b1, -900000));
        wait_idle();
    endtask

    function automatic logic [15:0] pick_count(input int top);
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(1, top));
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(32'h7FFF_FFFF));
            default: return $urandom_range(40000000);
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(16384, 262144);
        endcase
    endfunction

    // Fine code aimed mostly inside or at the edge of the trust window
    function automatic logic signed [23:0] pick_fine(input logic [1:0] range);
        longint gain;
        longint limit;
        longint cap;
        longint mag;
        gain  = (range == RNG_HIGH) ? cfg_gain_high : cfg_gain_mid;
        limit = (range == RNG_HIGH) ? cfg_limit_high : cfg_limit_mid;
        cap   = (gain == 0) ? 64'sd8388607 : (limit << 16) / gain;
        if (cap > 64'sd8388607) cap = 64'sd8388607;
        case ($urandom_range(19))
            0, 1, 2, 3: return 24'($urandom);
            4, 5, 6:    return 24'(int'($urandom_range(512)) - 256);
            7, 8, 9:    mag = cap + longint'($urandom_range(4)) - 2;
            default:    mag = $urandom_range(32'(cap));
        endcase
        if (mag < 0) mag = 0;
        if (mag > 64'sd8388607) mag = 64'sd8388607;
        if ($urandom_range(1)) mag = -mag;
        return mag[23:0];
    endfunction

    function automatic logic [1:0] pick_range();
        case ($urandom_range(9))
            0:          return RNG_UNKNOWN;
            1:          return RNG_LOW;
            2, 3, 4, 5: return RNG_MID;
            default:    return RNG_HIGH;
        endcase
    endfunction

    // Runs of one range, up to settle plus blend plus six requests long and at most 40, with some noise mixed in
    task automatic test_random_streams();
        fusion_sample_t s;
        logic [1:0]     cur_range;
        int             run_left;
        int             span;
        int             n_items;
        cur_range = RNG_MID;
        run_left  = 0;
        for (int ph = 0; ph < 16; ph++) begin
            set_idle_mode(ph % 4);
            write_reg(REG_SETTLE_COUNT, 32'(pick_count(6)));
            write_reg(REG_BLEND_COUNT, 32'(pick_count(10)));
            write_reg(REG_TRUST_LIMIT_HIGH, pick_limit());
            write_reg(REG_TRUST_LIMIT_MID, pick_limit());
            write_reg(REG_GAIN_COARSE, pick_gain());
            write_reg(REG_GAIN_MID, pick_gain());
            write_reg(REG_GAIN_HIGH, pick_gain());
            n_items = $urandom_range(70, 120);
            for (int i = 0; i < n_items; i++) begin
                if (run_left == 0) begin
                    cur_range = pick_range();
                    span = int'(cfg_settle) + int'(cfg_blend) + 6;
                    if (span > 40) span = 40;
                    run_left = $urandom_range(1, span);
                end
                run_left--;
                s.range     = ($urandom_range(9) == 0) ? 2'($urandom) : cur_range;
                s.fine_ok   = ($urandom_range(9) != 0);
                s.fine      = (s.range >= RNG_MID) ? pick_fine(s.range) : 24'($urandom);
                s.coarse_ok = ($urandom_range(9) != 0);
                s.coarse    = ($urandom_range(3) == 0) ? 24'(int'($urandom_range(2000)) - 1000)
                                                       : 24'($urandom);
                send_request(s);
            end
            wait_idle();
        end
    endtask

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each reading with the oldest prediction
    always @(posedge aclk) begin
        fusion_reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected reading: current %0d user %b",
                             $signed(m_tdata), m_tuser);
            end else begin
                want = expected_readings.pop_front();
                if (m_tdata !== want.current_na || m_tuser[1:0] !== want.source ||
                    m_tuser[2] !== want.missing || m_tuser[4:3] !== want.range) begin
                    mismatch_count++;
                    // fields: current, source, missing, range
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d %0d %0b %0d, got %0d %0d %0b %0d",
                                 want.current_na, want.source, want.missing, want.range,
                                 $signed(m_tdata), m_tuser[1:0], m_tuser[2], m_tuser[4:3]);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_saturation();
        test_settle_blend();
        test_blend_clamp();
        test_random_streams();

        wait_idle();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("dual_range_current_fusion_unit test passed");
        end else begin
            $display("dual_range_current_fusion_unit test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("dual_range_current_fusion_unit test failed");
        $finish;
    end

endmodule
